@@ rtl/mavgp_pkg.sv @@
// Package: shared types and constants of the moving-average distance predictor.
`default_nettype none

package mavgp_pkg;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_START,
        ST_DIV,
        ST_PRED,
        ST_OUT
    } t_state;

    // Register word indexes on the configuration port (byte address / 4).
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_INIT_DIST = 2'd0;
    localparam t_reg_idx REG_STEP_TIME = 2'd1;
    localparam t_reg_idx REG_THRESHOLD = 2'd2;

    localparam int unsigned APB_ADDR_W = 4;

    // Reset values of the configuration registers.
    localparam logic [15:0] INIT_DIST_RST = 16'd12800;
    localparam logic [15:0] STEP_TIME_RST = 16'd6554;
    localparam logic [15:0] THRESHOLD_RST = 16'd2560;

endpackage

`default_nettype wire

@@ rtl/mavgp_if.sv @@
// Interfaces: input and result word channels with valid/ready handshakes.
`default_nettype none

interface mavgp_in_if;
    logic               valid;
    logic               ready;
    logic        [15:0] sensor_distance;
    logic signed [15:0] closing_speed;

    modport source (output valid, output sensor_distance, output closing_speed, input ready);
    modport sink   (input valid, input sensor_distance, input closing_speed, output ready);
endinterface

interface mavgp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] next_estimate;
    logic [15:0] mean_distance;
    logic [15:0] divergence;
    logic        alarm;

    modport source (output valid, output next_estimate, output mean_distance,
                    output divergence, output alarm, input ready);
    modport sink   (input valid, input next_estimate, input mean_distance,
                    input divergence, input alarm, output ready);
endinterface

`default_nettype wire

@@ rtl/mavgp_div.sv @@
// Restoring divider: one quotient bit per cycle, unsigned.
`default_nettype none

module mavgp_div #(
    parameter int unsigned SUM_W = 19,
    parameter int unsigned CNT_W = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [SUM_W-1:0]      o_quotient
);
    localparam int unsigned STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_q;
    logic [CNT_W:0]    n_trial;

    // Dividend bits leave r_q at the top while quotient bits enter at the bottom.
    assign n_trial = {r_rem, r_q[SUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            if (n_trial >= {1'b0, i_divisor}) begin
                r_rem <= CNT_W'(n_trial - {1'b0, i_divisor});
                r_q   <= {r_q[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= n_trial[CNT_W-1:0];
                r_q   <= {r_q[SUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

@@ rtl/moving_average_predictor_anomaly_top.sv @@
// Top level: moving-average distance predictor with residual anomaly check.
//
// Each input word carries a Q8.8 distance sample and a signed Q8.8 closing
// speed. The sample is stored in a ring of WINDOW_DEPTH entries, the stored
// entries are averaged, and a result word returns the next prediction, the
// average, the divergence from the previous prediction and the anomaly flag.
// Both channels use valid/ready; a word moves when both are high.
// The block handles one word at a time. After acceptance it sums the stored
// entries through one adder, one entry per cycle, then a start state starts
// the restoring divider, which produces one quotient bit per cycle and then
// reports done, and a prediction state forms the prediction. The next word
// can be taken in the cycle after the result leaves. The result is held in
// output registers for as long as the receiver stalls, and no new word is
// accepted until it is taken.
// Reset (synchronous, active low) empties the ring, loads the registers with
// their defaults and sets the prediction to the initial distance. Writing the
// initial distance register over the APB port reloads the prediction only.
`default_nettype none

module moving_average_predictor_anomaly_top #(
    parameter int unsigned WINDOW_DEPTH = 5
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    mavgp_in_if.sink                            i_in,
    mavgp_out_if.source                         o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mavgp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import mavgp_pkg::*;

    localparam int unsigned IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SUM_W = 16 + $clog2(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(WINDOW_DEPTH);

    // Configuration registers.
    logic [15:0] r_init_dist;
    logic [15:0] r_step_time;
    logic [15:0] r_threshold;

    // Sample ring and its bookkeeping.
    logic [15:0]      r_ring [WINDOW_DEPTH];
    logic [IDX_W-1:0] r_wr_idx;
    logic             r_full;
    logic [15:0]      r_last_pred;

    // Per-word working registers.
    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_rd;
    logic [SUM_W-1:0]   r_acc;
    logic signed [32:0] r_prod;
    logic [15:0]        r_diverg;
    logic               r_anom;

    // Result registers.
    logic [15:0] r_o_pred;
    logic [15:0] r_o_smooth;

    logic               in_fire;
    logic               cfg_wr;
    logic               div_start;
    logic               div_done;
    logic [SUM_W-1:0]   div_q;
    logic [IDX_W-1:0]   n_wr_idx;
    logic               n_full;
    logic [CNT_W-1:0]   n_count;
    logic [15:0]        n_diverg;
    logic signed [16:0] speed_dt;
    logic signed [17:0] pred_raw;
    logic [15:0]        pred_sat;

    assign in_fire = i_in.valid && i_in.ready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            REG_INIT_DIST: prdata = {16'd0, r_init_dist};
            REG_STEP_TIME: prdata = {16'd0, r_step_time};
            REG_THRESHOLD: prdata = {16'd0, r_threshold};
            default:       prdata = '0;
        endcase
    end

    // Ring pointer after this word's sample is written; count of valid entries.
    always_comb begin
        if (r_wr_idx == IDX_W'(WINDOW_DEPTH - 1)) begin
            n_wr_idx = '0;
            n_full   = 1'b1;
        end else begin
            n_wr_idx = r_wr_idx + 1'b1;
            n_full   = r_full;
        end
        n_count = n_full ? DEPTH_C : CNT_W'(n_wr_idx);
    end

    assign n_diverg = (i_in.sensor_distance >= r_last_pred) ?
                      (i_in.sensor_distance - r_last_pred) :
                      (r_last_pred - i_in.sensor_distance);

    // Floor of speed * step time back to Q8.8 is an arithmetic shift by 16.
    assign speed_dt = r_prod[32:16];
    assign pred_raw = $signed({2'b00, div_q[15:0]}) - 18'(speed_dt);

    // Clamp at zero below and saturate at full scale above.
    always_comb begin
        if (pred_raw[17]) begin
            pred_sat = '0;
        end else if (pred_raw[16]) begin
            pred_sat = 16'hFFFF;
        end else begin
            pred_sat = pred_raw[15:0];
        end
    end

    // Sequencer: next state and control outputs.
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (r_rd == r_count - 1'b1) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_PRED;
                end
            end
            ST_PRED: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state: configuration, ring pointer and the running prediction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_dist <= INIT_DIST_RST;
            r_step_time <= STEP_TIME_RST;
            r_threshold <= THRESHOLD_RST;
            r_wr_idx    <= '0;
            r_full      <= 1'b0;
            r_last_pred <= INIT_DIST_RST;
        end else begin
            if (in_fire) begin
                r_wr_idx <= n_wr_idx;
                r_full   <= n_full;
            end
            if (r_state == ST_PRED) begin
                r_last_pred <= pred_sat;
            end
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_INIT_DIST: begin
                        r_init_dist <= pwdata[15:0];
                        r_last_pred <= pwdata[15:0];
                    end
                    REG_STEP_TIME: r_step_time <= pwdata[15:0];
                    REG_THRESHOLD: r_threshold <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Ring memory: written once per word, read one entry a cycle while summing.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ring[r_wr_idx] <= i_in.sensor_distance;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_count  <= n_count;
            r_rd     <= '0;
            r_acc    <= '0;
            r_prod   <= 33'(i_in.closing_speed) * 33'($signed({1'b0, r_step_time}));
            r_diverg <= n_diverg;
            r_anom   <= (n_diverg > r_threshold);
        end else if (r_state == ST_SUM) begin
            r_acc <= r_acc + SUM_W'(r_ring[r_rd[IDX_W-1:0]]);
            r_rd  <= r_rd + 1'b1;
        end
        if (r_state == ST_PRED) begin
            r_o_pred   <= pred_sat;
            r_o_smooth <= div_q[15:0];
        end
    end

    mavgp_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = (r_state == ST_OUT);
    assign o_out.next_estimate = r_o_pred;
    assign o_out.mean_distance = r_o_smooth;
    assign o_out.divergence    = r_diverg;
    assign o_out.alarm         = r_anom;

endmodule

`default_nettype wire

@@ tb/dist_predict_checker.sv @@
// Checker: watches both word channels and the register port, predicts each result and compares.
module dist_predict_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mavgp_in_if                              in_ch,
    mavgp_out_if                             out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mavgp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                      pwdata,
    input  logic [31:0]                      prdata,
    input  logic                             pready,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import mavgp_pkg::*;

    localparam int unsigned DEPTH = 5;

    typedef struct packed {
        logic [15:0] predicted;
        logic [15:0] smoothed;
        logic [15:0] divergence;
        logic        anomaly;
    } t_exp_result;

    // Shadow copy of the registers and of the block's history.
    logic [15:0]  init_dist;
    logic [15:0]  step_time;
    logic [15:0]  threshold;
    logic [15:0]  sample_hist [DEPTH];
    int unsigned  hist_wr_idx;
    bit           hist_full;
    logic [15:0]  prev_prediction;

    t_exp_result  expected_results [$];
    int           fails;
    int           checked;

    // Stores the sample, averages the history and forms the next prediction.
    function automatic t_exp_result predict_next_result(input logic [15:0] sensor,
                                                        input logic signed [15:0] speed);
        t_exp_result res;
        int unsigned cnt;
        int unsigned sum;
        int unsigned avg;
        longint      prod;
        longint      next_pred;
        sample_hist[hist_wr_idx] = sensor;
        hist_wr_idx++;
        if (hist_wr_idx >= DEPTH) begin
            hist_wr_idx = 0;
            hist_full   = 1'b1;
        end
        cnt = hist_full ? DEPTH : hist_wr_idx;
        if (cnt == 0) begin
            cnt = 1;
        end
        sum = 0;
        for (int unsigned k = 0; k < cnt; k++) begin
            sum += sample_hist[k];
        end
        avg = sum / cnt;
        res.smoothed   = avg[15:0];
        res.divergence = (sensor >= prev_prediction) ? sensor - prev_prediction
                                                     : prev_prediction - sensor;
        res.anomaly    = (res.divergence > threshold);
        // Q8.8 times Q0.16 is exact in Q8.24; the arithmetic shift floors it to Q8.8.
        prod      = longint'(speed) * longint'(step_time);
        next_pred = longint'(avg) - (prod >>> 16);
        if (next_pred < 0) begin
            next_pred = 0;
        end
        if (next_pred > 65535) begin
            next_pred = 65535;
        end
        prev_prediction = next_pred[15:0];
        res.predicted   = next_pred[15:0];
        return res;
    endfunction

    function automatic logic [15:0] reg_value(input t_reg_idx idx);
        case (idx)
            REG_INIT_DIST: return init_dist;
            REG_STEP_TIME: return step_time;
            default:       return threshold;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_exp_result exp_res;
        t_reg_idx    idx;
        idx = paddr[3:2];
        if (!i_rst_n) begin
            init_dist       = INIT_DIST_RST;
            step_time       = STEP_TIME_RST;
            threshold       = THRESHOLD_RST;
            prev_prediction = INIT_DIST_RST;
            hist_wr_idx     = 0;
            hist_full       = 1'b0;
            foreach (sample_hist[k]) begin
                sample_hist[k] = '0;
            end
            expected_results.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (psel && penable && pready && pwrite) begin
                case (idx)
                    REG_INIT_DIST: begin
                        init_dist       = pwdata[15:0];
                        prev_prediction = pwdata[15:0];
                    end
                    REG_STEP_TIME: step_time = pwdata[15:0];
                    REG_THRESHOLD: threshold = pwdata[15:0];
                    default: ;
                endcase
            end
            if (psel && penable && pready && !pwrite &&
                (idx == REG_INIT_DIST || idx == REG_STEP_TIME || idx == REG_THRESHOLD)) begin
                if (prdata !== {16'h0, reg_value(idx)}) begin
                    $error("register read at %0d: expected %0d actual %0d",
                           idx, reg_value(idx), prdata);
                    fails++;
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(
                    predict_next_result(in_ch.sensor_distance, in_ch.closing_speed));
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word arrived with no expectation waiting");
                    fails++;
                end else begin
                    exp_res = expected_results.pop_front();
                    checked++;
                    if (out_ch.next_estimate !== exp_res.predicted) begin
                        $error("next_estimate: expected %0d actual %0d",
                               exp_res.predicted, out_ch.next_estimate);
                        fails++;
                    end
                    if (out_ch.mean_distance !== exp_res.smoothed) begin
                        $error("mean_distance: expected %0d actual %0d",
                               exp_res.smoothed, out_ch.mean_distance);
                        fails++;
                    end
                    if (out_ch.divergence !== exp_res.divergence) begin
                        $error("divergence: expected %0d actual %0d",
                               exp_res.divergence, out_ch.divergence);
                        fails++;
                    end
                    if (out_ch.alarm !== exp_res.anomaly) begin
                        $error("alarm: expected %0d actual %0d",
                               exp_res.anomaly, out_ch.alarm);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
        o_checked    <= checked;
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top: clock, reset, stimulus on the word channels and register port, and the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mavgp_pkg::*;

    // Register index that decodes to no register; writes there must change nothing.
    localparam t_reg_idx REG_SPARE = 2'd3;

    localparam int RAND_PHASES  = 6;
    localparam int PHASE_WORDS  = 260;
    // The limit is far above the slowest honest run.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int checked;
    int cycles;
    int idle_pct;
    int words_sent;
    int reg_writes;

    mavgp_in_if  in_ch();
    mavgp_out_if out_ch();

    moving_average_predictor_anomaly_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The checker sits beside the block and sees exactly what crosses its ports.
    dist_predict_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 10 ns clock, starting low.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // The receiver stalls at the same rate the sender idles; idle_pct of zero
    // gives a stretch where the result side never pushes back.
    always @(posedge i_clk) begin
        if (!i_rst_n || idle_pct == 0) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // One register write: setup phase, then access phase until pready is seen.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
        @(posedge i_clk);
    endtask

    // One register read; the checker compares prdata with its shadow copy.
    task automatic read_reg(input t_reg_idx idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes all three registers and reads them back.
    task automatic set_regs(input logic [15:0] init, input logic [15:0] step,
                            input logic [15:0] thr);
        write_reg(REG_INIT_DIST, {16'h0, init});
        write_reg(REG_STEP_TIME, {16'h0, step});
        write_reg(REG_THRESHOLD, {16'h0, thr});
        read_reg(REG_INIT_DIST);
        read_reg(REG_STEP_TIME);
        read_reg(REG_THRESHOLD);
    endtask

    // Offers one word, with random idle cycles ahead of it, and returns at
    // the edge where it is accepted. While idling the payload carries noise.
    task automatic send_word(input logic [15:0] sensor, input logic signed [15:0] speed);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            in_ch.valid           <= 1'b0;
            in_ch.sensor_distance <= 16'($urandom);
            in_ch.closing_speed   <= 16'($urandom);
            @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.sensor_distance <= sensor;
        in_ch.closing_speed   <= speed;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
    endtask

    // Stops offering words and waits until every expected result has been taken.
    // Every word yields a result, so the block is idle once nothing is pending.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Picks a register value, with the extremes of the range weighted up.
    function automatic logic [15:0] pick_reg_value();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int          traj;
        int          noise_span;
        int          dist_val;
        logic [15:0] cfg_init;
        logic [15:0] cfg_step;
        logic [15:0] cfg_thr;
        logic [15:0] sample_val;
        logic [15:0] speed;

        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        in_ch.valid           = 1'b0;
        in_ch.sensor_distance = '0;
        in_ch.closing_speed   = '0;
        words_sent            = 0;
        reg_writes            = 0;
        idle_pct              = 34;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Reset values first: read them back, then fill the
        // ring and run one word past the wrap, with zero and full-scale
        // samples, small speeds of both signs and a full positive speed.
        read_reg(REG_INIT_DIST);
        read_reg(REG_STEP_TIME);
        read_reg(REG_THRESHOLD);
        send_word(16'd0, 16'sd0);
        send_word(16'hFFFF, 16'sd0);
        send_word(16'd12800, 16'sd256);
        send_word(16'd300, -16'sd1);
        send_word(16'd0, 16'sd1);
        send_word(16'd1, 16'sd32767);

        // Longest step time: a full negative speed raises the prediction by the
        // largest step, a full positive speed drives it below zero.
        wait_drained();
        set_regs(16'd0, 16'hFFFF, 16'd0);
        send_word(16'hFFFF, -16'sd32768);
        send_word(16'd0, 16'sd32767);
        send_word(16'd40000, -16'sd32768);

        // Zero step time makes the prediction equal the average. Divergence
        // exactly at the threshold must not flag; one above it must.
        wait_drained();
        set_regs(16'd1000, 16'd0, 16'd500);
        send_word(16'd1500, 16'sd12345);
        wait_drained();
        write_reg(REG_INIT_DIST, 32'd1000);
        send_word(16'd1501, -16'sd999);
        wait_drained();
        write_reg(REG_INIT_DIST, 32'd1000);
        send_word(16'd499, 16'sd0);
        send_word(16'd2000, 16'sd0);

        // A write to the unmapped index must leave every register alone.
        wait_drained();
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        set_regs(16'hFFFF, 16'd1, 16'hFFFF);
        write_reg(REG_SPARE, 32'h0000_5A5A);
        read_reg(REG_INIT_DIST);
        read_reg(REG_STEP_TIME);
        read_reg(REG_THRESHOLD);
        send_word(16'd0, -16'sd32768);
        send_word(16'hFFFF, 16'sd32767);
        send_word(16'h8000, -16'sd1);

        // Random part: several phases, each with its own register setting.
        // Samples mostly follow a slowly drifting distance with noise around
        // the threshold, so the anomaly flag takes both values often.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            // Phase two runs with neither side ever idling.
            idle_pct = (ph == 2) ? 0 : 34;
            cfg_init = pick_reg_value();
            cfg_step = pick_reg_value();
            cfg_thr  = ($urandom_range(2) == 0) ? pick_reg_value()
                                                : 16'($urandom_range(4000));
            set_regs(cfg_init, cfg_step, cfg_thr);
            traj       = cfg_init;
            noise_span = (cfg_thr < 16'd16000) ? 2 * cfg_thr + 64 : 32768;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                traj = traj + $urandom_range(800) - 400;
                if (traj < 0) begin
                    traj = 0;
                end
                if (traj > 65535) begin
                    traj = 65535;
                end
                case ($urandom_range(9))
                    0:       sample_val = 16'h0000;
                    1:       sample_val = 16'hFFFF;
                    2, 3:    sample_val = 16'($urandom);
                    default: begin
                        dist_val = traj + $urandom_range(noise_span) - noise_span / 2;
                        if (dist_val < 0) begin
                            dist_val = 0;
                        end
                        if (dist_val > 65535) begin
                            dist_val = 65535;
                        end
                        sample_val = dist_val[15:0];
                    end
                endcase
                case ($urandom_range(4))
                    0:       speed = 16'($urandom);
                    default: speed = 16'($urandom_range(4096)) - 16'd2048;
                endcase
                send_word(sample_val, speed);
            end
        end

        // Let everything drain, keep watching for a tail period in case a stray
        // result shows up, then give the verdict.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d input words and %0d compared results under %0d register writes,",
                 words_sent, checked, reg_writes);
        $display("directed corners plus %0d random phases, one of them without idling.",
                 RAND_PHASES);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mavgp_pkg.sv
rtl/mavgp_if.sv
rtl/mavgp_div.sv
rtl/moving_average_predictor_anomaly_top.sv
tb/dist_predict_checker.sv
tb/tb_top.sv
